FILE: hw/rtl/assert_macros.svh
// assertion macros used by the three plane intersection top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define TPI_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// delayed implication, the delay given by argument n
`define TPI_ASSERT_DELAY(label, ante, n, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##(n) (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/tpi_pkg.sv
// shared types and constant tables for the three plane intersection block
package tpi_pkg;

   localparam int NUM_COLS  = 4;
   localparam int NUM_PAIRS = 6;
   localparam int NUM_DETS  = 4;
   localparam int NUM_TERMS = 3;
   localparam int NUM_COORD = 3;

   typedef logic [1:0] col_idx_type;
   typedef logic [2:0] pair_idx_type;

   // columns of one plane row: normal x, y, z and distance
   localparam col_idx_type COL_X = 2'd0;
   localparam col_idx_type COL_Y = 2'd1;
   localparam col_idx_type COL_Z = 2'd2;
   localparam col_idx_type COL_D = 2'd3;

   // 2x2 minors of rows two and three, one per column pair
   localparam pair_idx_type PAIR_XY = 3'd0;
   localparam pair_idx_type PAIR_XZ = 3'd1;
   localparam pair_idx_type PAIR_XD = 3'd2;
   localparam pair_idx_type PAIR_YZ = 3'd3;
   localparam pair_idx_type PAIR_YD = 3'd4;
   localparam pair_idx_type PAIR_ZD = 3'd5;

   localparam col_idx_type PAIR_FIRST [NUM_PAIRS] = '{COL_X, COL_X, COL_X, COL_Y, COL_Y, COL_Z};
   localparam col_idx_type PAIR_SECOND[NUM_PAIRS] = '{COL_Y, COL_Z, COL_D, COL_Z, COL_D, COL_D};

   // first-row expansion of det, det_x, det_y, det_z
   localparam col_idx_type TERM_COEF[NUM_DETS][NUM_TERMS] = '{
      '{COL_X, COL_Y, COL_Z},
      '{COL_D, COL_Y, COL_Z},
      '{COL_X, COL_D, COL_Z},
      '{COL_X, COL_Y, COL_D}};
   localparam pair_idx_type TERM_PAIR[NUM_DETS][NUM_TERMS] = '{
      '{PAIR_YZ, PAIR_XZ, PAIR_XY},
      '{PAIR_YZ, PAIR_ZD, PAIR_YD},
      '{PAIR_ZD, PAIR_XZ, PAIR_XD},
      '{PAIR_YD, PAIR_XD, PAIR_XY}};
   localparam logic TERM_NEG[NUM_DETS][NUM_TERMS] = '{
      '{1'b0, 1'b1, 1'b0},
      '{1'b0, 1'b0, 1'b1},
      '{1'b1, 1'b1, 1'b0},
      '{1'b0, 1'b1, 1'b0}};

   // sideband that travels with each divider stage
   typedef struct packed {
      logic valid;
      logic singular;
      logic neg;
   } tpi_ctl_type;

endpackage

FILE: hw/rtl/tpi_det.sv
// five stage pipeline forming the system determinant and the three cramer determinants
module tpi_det #(
   parameter int VALUE_WIDTH = 32,
   parameter int DET_WIDTH   = 99
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          valid_in,
   input  logic signed [VALUE_WIDTH-1:0] row1_in [tpi_pkg::NUM_COLS],
   input  logic signed [VALUE_WIDTH-1:0] row2_in [tpi_pkg::NUM_COLS],
   input  logic signed [VALUE_WIDTH-1:0] row3_in [tpi_pkg::NUM_COLS],
   output logic                          valid_out,
   output logic signed [DET_WIDTH-1:0]   det_out [tpi_pkg::NUM_DETS]
);
   import tpi_pkg::*;

   localparam int PW = 2 * VALUE_WIDTH;
   localparam int MW = 2 * VALUE_WIDTH + 1;
   localparam int TW = 3 * VALUE_WIDTH + 2;

   logic [4:0] valid_ff;

   logic signed [VALUE_WIDTH-1:0] row1_s1_ff [NUM_COLS];
   logic signed [VALUE_WIDTH-1:0] row1_s2_ff [NUM_COLS];
   logic signed [PW-1:0]          prod_a_ff  [NUM_PAIRS];
   logic signed [PW-1:0]          prod_b_ff  [NUM_PAIRS];
   logic signed [MW-1:0]          minor_ff   [NUM_PAIRS];
   logic signed [MW-1:0]          part_lo_ff [NUM_DETS][NUM_TERMS];
   logic signed [MW-1:0]          part_hi_ff [NUM_DETS][NUM_TERMS];
   logic signed [TW-1:0]          term_ff    [NUM_DETS][NUM_TERMS];
   logic signed [DET_WIDTH-1:0]   det_in     [NUM_DETS];
   logic signed [DET_WIDTH-1:0]   det_ff     [NUM_DETS];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[3:0], valid_in};
      end
   end

   // stage 1: products of rows two and three
   always_ff @(posedge clock) begin
      row1_s1_ff <= row1_in;
      for (int p = 0; p < NUM_PAIRS; p++) begin
         prod_a_ff[p] <= row2_in[PAIR_FIRST[p]] * row3_in[PAIR_SECOND[p]];
         prod_b_ff[p] <= row2_in[PAIR_SECOND[p]] * row3_in[PAIR_FIRST[p]];
      end
   end

   // stage 2: minors
   always_ff @(posedge clock) begin
      row1_s2_ff <= row1_s1_ff;
      for (int p = 0; p < NUM_PAIRS; p++) begin
         minor_ff[p] <= MW'(prod_a_ff[p]) - MW'(prod_b_ff[p]);
      end
   end

   // stage 3: first-row entry times minor, minor split in low and high halves
   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_DETS; k++) begin
         for (int t = 0; t < NUM_TERMS; t++) begin
            part_lo_ff[k][t] <= row1_s2_ff[TERM_COEF[k][t]]
               * $signed({1'b0, minor_ff[TERM_PAIR[k][t]][VALUE_WIDTH-1:0]});
            part_hi_ff[k][t] <= row1_s2_ff[TERM_COEF[k][t]]
               * $signed(minor_ff[TERM_PAIR[k][t]][MW-1:VALUE_WIDTH]);
         end
      end
   end

   // stage 4: recombine the halves
   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_DETS; k++) begin
         for (int t = 0; t < NUM_TERMS; t++) begin
            term_ff[k][t] <= (TW'(part_hi_ff[k][t]) <<< VALUE_WIDTH) + TW'(part_lo_ff[k][t]);
         end
      end
   end

   // stage 5: signed sum of the three terms
   always_comb begin
      for (int k = 0; k < NUM_DETS; k++) begin
         det_in[k] = '0;
         for (int t = 0; t < NUM_TERMS; t++) begin
            if (TERM_NEG[k][t]) begin
               det_in[k] = det_in[k] - DET_WIDTH'(term_ff[k][t]);
            end else begin
               det_in[k] = det_in[k] + DET_WIDTH'(term_ff[k][t]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      det_ff <= det_in;
   end

   assign valid_out = valid_ff[4];
   assign det_out   = det_ff;

endmodule

FILE: hw/rtl/tpi_div.sv
// pipelined restoring divider, one quotient bit per stage, with overflow bit
module tpi_div #(
   parameter int VALUE_WIDTH = 32,
   parameter int FRAC_BITS   = 16,
   parameter int DET_WIDTH   = 99
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tpi_pkg::tpi_ctl_type        ctl_in,
   input  logic [DET_WIDTH-1:0]        num_in,
   input  logic [DET_WIDTH-1:0]        den_in,
   output tpi_pkg::tpi_ctl_type        ctl_out,
   output logic [VALUE_WIDTH-1:0]      quot_out,
   output logic                        ovf_out
);
   import tpi_pkg::*;

   localparam int RW     = DET_WIDTH + VALUE_WIDTH + FRAC_BITS;
   localparam int STAGES = VALUE_WIDTH + 1;

   tpi_ctl_type            ctl_ff  [STAGES];
   logic [RW-1:0]          rem_ff  [STAGES];
   logic [DET_WIDTH-1:0]   den_ff  [STAGES];
   logic [VALUE_WIDTH-1:0] quot_ff [STAGES];
   logic                   ovf_ff  [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_step
      tpi_ctl_type            ctl_prev;
      logic [RW-1:0]          rem_prev;
      logic [RW-1:0]          trial;
      logic [RW-1:0]          rem_in;
      logic [DET_WIDTH-1:0]   den_prev;
      logic [VALUE_WIDTH-1:0] quot_prev;
      logic [VALUE_WIDTH-1:0] quot_in;
      logic                   ovf_prev;
      logic                   ovf_in;
      logic                   qbit;

      if (s == 0) begin : g_first
         assign ctl_prev  = ctl_in;
         assign rem_prev  = RW'(num_in) << FRAC_BITS;
         assign den_prev  = den_in;
         assign quot_prev = '0;
         assign ovf_prev  = 1'b0;
      end else begin : g_next
         assign ctl_prev  = ctl_ff[s-1];
         assign rem_prev  = rem_ff[s-1];
         assign den_prev  = den_ff[s-1];
         assign quot_prev = quot_ff[s-1];
         assign ovf_prev  = ovf_ff[s-1];
      end

      // first stage tests the bit above the result range
      assign trial   = RW'(den_prev) << (VALUE_WIDTH - s);
      assign qbit    = rem_prev >= trial;
      assign rem_in  = qbit ? rem_prev - trial : rem_prev;
      assign quot_in = (s == 0) ? quot_prev : {quot_prev[VALUE_WIDTH-2:0], qbit};
      assign ovf_in  = (s == 0) ? qbit : ovf_prev;

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s].valid <= 1'b0;
         end else begin
            ctl_ff[s].valid <= ctl_prev.valid;
         end
         ctl_ff[s].singular <= ctl_prev.singular;
         ctl_ff[s].neg      <= ctl_prev.neg;
         rem_ff[s]  <= rem_in;
         den_ff[s]  <= den_prev;
         quot_ff[s] <= quot_in;
         ovf_ff[s]  <= ovf_in;
      end
   end

   assign ctl_out  = ctl_ff[STAGES-1];
   assign quot_out = quot_ff[STAGES-1];
   assign ovf_out  = ovf_ff[STAGES-1] | (|rem_ff[STAGES-1] & 1'b0) | (|den_ff[STAGES-1] & 1'b0);

endmodule

FILE: hw/rtl/three_plane_intersection.sv
// top level of the three plane intersection solver
//
//   channel   ports                       handshake
//   request   req_plane*_nx/ny/nz/dist    start high and busy low at the clock edge
//   response  rsp_solution_x/y/z, solved  rsp_strobe high for one cycle, no backpressure
//             rsp_clamped
//
// the path runs through five determinant stages, one sign/magnitude stage,
// VALUE_WIDTH + 1 divider stages and the output register; the divider is the
// deepest part of the pipe
// one item is taken every cycle, busy never rises
// reset clears only the valid bits along the pipe, data registers are not reset
// the receiver cannot stall, so there is no stall path anywhere in the pipe
module three_plane_intersection #(
   parameter int VALUE_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [VALUE_WIDTH-1:0] req_plane1_nx,
   input  logic signed [VALUE_WIDTH-1:0] req_plane1_ny,
   input  logic signed [VALUE_WIDTH-1:0] req_plane1_nz,
   input  logic signed [VALUE_WIDTH-1:0] req_plane1_dist,
   input  logic signed [VALUE_WIDTH-1:0] req_plane2_nx,
   input  logic signed [VALUE_WIDTH-1:0] req_plane2_ny,
   input  logic signed [VALUE_WIDTH-1:0] req_plane2_nz,
   input  logic signed [VALUE_WIDTH-1:0] req_plane2_dist,
   input  logic signed [VALUE_WIDTH-1:0] req_plane3_nx,
   input  logic signed [VALUE_WIDTH-1:0] req_plane3_ny,
   input  logic signed [VALUE_WIDTH-1:0] req_plane3_nz,
   input  logic signed [VALUE_WIDTH-1:0] req_plane3_dist,
   output logic                          rsp_strobe,
   output logic signed [VALUE_WIDTH-1:0] rsp_solution_x,
   output logic signed [VALUE_WIDTH-1:0] rsp_solution_y,
   output logic signed [VALUE_WIDTH-1:0] rsp_solution_z,
   output logic                          rsp_solved,
   output logic                          rsp_clamped
);
   import tpi_pkg::*;
   `include "assert_macros.svh"

   // three products of a value and a 2x2 minor fit in this width
   localparam int DET_WIDTH = 3 * VALUE_WIDTH + 3;
   localparam int LATENCY   = VALUE_WIDTH + 8;

   localparam logic [VALUE_WIDTH-1:0] POS_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic [VALUE_WIDTH-1:0] NEG_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   logic accept;

   logic signed [VALUE_WIDTH-1:0] row1 [NUM_COLS];
   logic signed [VALUE_WIDTH-1:0] row2 [NUM_COLS];
   logic signed [VALUE_WIDTH-1:0] row3 [NUM_COLS];

   logic                        det_valid;
   logic signed [DET_WIDTH-1:0] det [NUM_DETS];

   // sign/magnitude stage
   tpi_ctl_type            ctl_in  [NUM_COORD];
   logic [DET_WIDTH-1:0]   num_in  [NUM_COORD];
   logic [DET_WIDTH-1:0]   den_in;
   tpi_ctl_type            ctl_ff  [NUM_COORD];
   logic [DET_WIDTH-1:0]   num_ff  [NUM_COORD];
   logic [DET_WIDTH-1:0]   den_ff;

   // divider outputs
   tpi_ctl_type            div_ctl  [NUM_COORD];
   logic [VALUE_WIDTH-1:0] div_quot [NUM_COORD];
   logic                   div_ovf  [NUM_COORD];

   // output stage
   logic [VALUE_WIDTH-1:0] coord_in [NUM_COORD];
   logic [NUM_COORD-1:0]   sat_in;
   logic                   strobe_ff;
   logic [VALUE_WIDTH-1:0] coord_ff [NUM_COORD];
   logic                   solved_ff;
   logic                   clamped_ff;

   // the pipe never stalls, so every start is taken
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   assign row1 = '{req_plane1_nx, req_plane1_ny, req_plane1_nz, req_plane1_dist};
   assign row2 = '{req_plane2_nx, req_plane2_ny, req_plane2_nz, req_plane2_dist};
   assign row3 = '{req_plane3_nx, req_plane3_ny, req_plane3_nz, req_plane3_dist};

   tpi_det #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .DET_WIDTH  (DET_WIDTH)
   ) u_det (
      .clock    (clock),
      .reset    (reset),
      .valid_in (accept),
      .row1_in  (row1),
      .row2_in  (row2),
      .row3_in  (row3),
      .valid_out(det_valid),
      .det_out  (det)
   );

   // magnitudes for the unsigned divider, result sign from the two signs
   assign den_in = det[0][DET_WIDTH-1] ? DET_WIDTH'(-det[0]) : DET_WIDTH'(det[0]);

   always_comb begin
      for (int c = 0; c < NUM_COORD; c++) begin
         ctl_in[c].valid    = det_valid;
         ctl_in[c].singular = (det[0] == '0);
         ctl_in[c].neg      = det[c+1][DET_WIDTH-1] ^ det[0][DET_WIDTH-1];
         num_in[c] = det[c+1][DET_WIDTH-1] ? DET_WIDTH'(-det[c+1]) : DET_WIDTH'(det[c+1]);
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      for (int c = 0; c < NUM_COORD; c++) begin
         if (reset) begin
            ctl_ff[c].valid <= 1'b0;
         end else begin
            ctl_ff[c].valid <= ctl_in[c].valid;
         end
         ctl_ff[c].singular <= ctl_in[c].singular;
         ctl_ff[c].neg      <= ctl_in[c].neg;
      end
   end

   for (genvar c = 0; c < NUM_COORD; c++) begin : g_coord
      tpi_div #(
         .VALUE_WIDTH(VALUE_WIDTH),
         .FRAC_BITS  (FRAC_BITS),
         .DET_WIDTH  (DET_WIDTH)
      ) u_div (
         .clock   (clock),
         .reset   (reset),
         .ctl_in  (ctl_ff[c]),
         .num_in  (num_ff[c]),
         .den_in  (den_ff),
         .ctl_out (div_ctl[c]),
         .quot_out(div_quot[c]),
         .ovf_out (div_ovf[c])
      );
   end

   // saturation: a negative result may reach the most negative code exactly
   always_comb begin
      for (int c = 0; c < NUM_COORD; c++) begin
         if (div_ctl[c].neg) begin
            sat_in[c] = div_ovf[c] | (div_quot[c] > NEG_MIN);
         end else begin
            sat_in[c] = div_ovf[c] | div_quot[c][VALUE_WIDTH-1];
         end
         if (div_ctl[c].singular) begin
            sat_in[c]   = 1'b0;
            coord_in[c] = '0;
         end else if (sat_in[c]) begin
            coord_in[c] = div_ctl[c].neg ? NEG_MIN : POS_MAX;
         end else begin
            coord_in[c] = div_ctl[c].neg ? VALUE_WIDTH'(-div_quot[c]) : div_quot[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      coord_ff   <= coord_in;
      solved_ff  <= ~div_ctl[0].singular;
      clamped_ff <= |sat_in;
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= div_ctl[0].valid;
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_solution_x = coord_ff[0];
   assign rsp_solution_y = coord_ff[1];
   assign rsp_solution_z = coord_ff[2];
   assign rsp_solved     = solved_ff;
   assign rsp_clamped    = clamped_ff;

   // every accepted item must later come out as a result strobe
   `TPI_ASSERT_DELAY(a_latency, accept, LATENCY, rsp_strobe, "item did not emerge on time")
   // a singular system reports a zero point and no clamp
   `TPI_ASSERT_IMPLY(a_singular_zero, rsp_strobe && !rsp_solved,
      (!rsp_clamped) && (rsp_solution_x == '0) && (rsp_solution_y == '0)
         && (rsp_solution_z == '0),
      "singular item has nonzero fields")
   // the three dividers stay in lockstep
   `TPI_ASSERT_IMPLY(a_lockstep, div_ctl[0].valid || div_ctl[1].valid || div_ctl[2].valid,
      div_ctl[0].valid && div_ctl[1].valid && div_ctl[2].valid
         && (div_ctl[0].singular == div_ctl[2].singular),
      "divider lanes out of step")

endmodule

FILE: bench/three_plane_intersection_tb.sv
// self-checking testbench for the three plane intersection solver
module three_plane_intersection_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VW         = 32;
   localparam int FB         = 16;
   localparam int LATENCY    = VW + 8;
   localparam int NUM_RANDOM = 1450;
   localparam int CYCLE_CAP  = 200000;
   localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
   localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
   localparam logic signed [VW-1:0] ONE  = 32'sh0001_0000;

   typedef logic signed [VW-1:0] value_type;
   // determinants of Q16.16 entries fit well inside 128 bits, shifted by FB too
   typedef logic signed [159:0] det_type;

   // one plane triple, rows are planes, columns nx ny nz dist
   typedef struct {
      value_type m[3][4];
   } planes_type;

   typedef struct {
      value_type x, y, z;
      logic      solved;
      logic      clamped;
   } point_type;

   // one directed row; has_fixed marks rows whose answer is typed in
   typedef struct {
      planes_type p;
      logic       has_fixed;
      point_type  fixed;
   } vector_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   value_type req_v[3][4];
   logic      rsp_strobe;
   value_type rsp_solution_x, rsp_solution_y, rsp_solution_z;
   logic      rsp_solved, rsp_clamped;

   point_type expected_points[$];
   int        error_count = 0;
   int        cycle_count = 0;

   always #5 clock = ~clock;

   three_plane_intersection #(.VALUE_WIDTH(VW), .FRAC_BITS(FB)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_plane1_nx(req_v[0][0]), .req_plane1_ny(req_v[0][1]),
      .req_plane1_nz(req_v[0][2]), .req_plane1_dist(req_v[0][3]),
      .req_plane2_nx(req_v[1][0]), .req_plane2_ny(req_v[1][1]),
      .req_plane2_nz(req_v[1][2]), .req_plane2_dist(req_v[1][3]),
      .req_plane3_nx(req_v[2][0]), .req_plane3_ny(req_v[2][1]),
      .req_plane3_nz(req_v[2][2]), .req_plane3_dist(req_v[2][3]),
      .rsp_strobe(rsp_strobe), .rsp_solution_x(rsp_solution_x),
      .rsp_solution_y(rsp_solution_y), .rsp_solution_z(rsp_solution_z),
      .rsp_solved(rsp_solved), .rsp_clamped(rsp_clamped));

   // 3x3 determinant with column col swapped for the distances (col 3 = none)
   function automatic det_type plane_det(planes_type p, int col);
      det_type e[3][3];
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            e[r][c] = (c == col) ? det_type'(p.m[r][3]) : det_type'(p.m[r][c]);
      return e[0][0] * (e[1][1] * e[2][2] - e[1][2] * e[2][1])
           - e[0][1] * (e[1][0] * e[2][2] - e[1][2] * e[2][0])
           + e[0][2] * (e[1][0] * e[2][1] - e[1][1] * e[2][0]);
   endfunction

   // cramer's rule with truncation toward zero and saturation to the value range
   function automatic point_type solve_planes(planes_type p);
      point_type res;
      det_type   den, q;
      value_type coord[3];
      res = '{default: '0};
      den = plane_det(p, 3);
      if (den == 0) return res;
      res.solved = 1'b1;
      for (int k = 0; k < 3; k++) begin
         // sv signed division truncates toward zero
         q = (plane_det(p, k) <<< FB) / den;
         if (q > det_type'(VMAX)) begin
            coord[k] = VMAX;
            res.clamped = 1'b1;
         end else if (q < det_type'(VMIN)) begin
            coord[k] = VMIN;
            res.clamped = 1'b1;
         end else begin
            coord[k] = value_type'(q);
         end
      end
      res.x = coord[0];
      res.y = coord[1];
      res.z = coord[2];
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      error_count++;
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
   endtask

   // drive one item and hold it until accepted; start stays high across a burst
   task automatic send_planes(planes_type p, point_type want);
      start <= 1'b1;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 4; c++)
            req_v[r][c] <= p.m[r][c];
      do @(posedge clock); while (busy);
      expected_points.push_back(want);
   endtask

   task automatic idle_cycles(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   function automatic value_type random_value();
      case ($urandom_range(0, 9))
         0:       return VMAX;
         1:       return VMIN;
         2:       return value_type'(0);
         3, 4:    return value_type'($urandom_range(0, 8 << FB)) - value_type'(4 << FB);
         5:       return value_type'($urandom_range(0, 255)) - value_type'(128);
         default: return value_type'($urandom);
      endcase
   endfunction

   function automatic planes_type random_planes();
      planes_type p;
      int         shape;
      int         zero_col;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 4; c++)
            p.m[r][c] = random_value();
      shape = $urandom_range(0, 9);
      zero_col = $urandom_range(0, 2);
      // singular systems: repeated or scaled rows, or a zero column
      if (shape == 0) p.m[2] = p.m[0];
      else if (shape == 1)
         for (int c = 0; c < 4; c++) p.m[1][c] = -p.m[0][c];
      else if (shape == 2)
         for (int r = 0; r < 3; r++) p.m[r][zero_col] = '0;
      return p;
   endfunction

   function automatic planes_type make_planes(
      value_type a0, value_type a1, value_type a2, value_type a3,
      value_type b0, value_type b1, value_type b2, value_type b3,
      value_type c0, value_type c1, value_type c2, value_type c3);
      planes_type p;
      p.m = '{'{a0, a1, a2, a3}, '{b0, b1, b2, b3}, '{c0, c1, c2, c3}};
      return p;
   endfunction

   // result side: every strobe is one result, compared with the oldest expectation
   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp_strobe) begin
         if (expected_points.size() == 0) begin
            report_mismatch("unexpected result, solution_x", rsp_solution_x, 0);
         end else begin
            want = expected_points.pop_front();
            if (rsp_solution_x !== want.x) report_mismatch("solution_x", rsp_solution_x, want.x);
            if (rsp_solution_y !== want.y) report_mismatch("solution_y", rsp_solution_y, want.y);
            if (rsp_solution_z !== want.z) report_mismatch("solution_z", rsp_solution_z, want.z);
            if (rsp_solved !== want.solved) report_mismatch("solved", rsp_solved, want.solved);
            if (rsp_clamped !== want.clamped)
               report_mismatch("clamped", rsp_clamped, want.clamped);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("** three_plane_intersection: FAILED **");
         $finish;
      end
   end

   initial begin
      vector_type directed[$];
      vector_type row;
      planes_type p;
      point_type  want;
      int         burst, wait_count;

      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 4; c++)
            req_v[r][c] = '0;

      // identity normals give the distances back as the point
      row.p = make_planes(ONE, 0, 0, 5 << FB, 0, ONE, 0, -(3 << FB), 0, 0, ONE, ONE);
      row.has_fixed = 1'b1;
      row.fixed = '{5 << FB, -(3 << FB), ONE, 1'b1, 1'b0};
      directed.push_back(row);
      // all zero: singular
      row.p = make_planes(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      row.fixed = '{0, 0, 0, 1'b0, 1'b0};
      directed.push_back(row);
      // singular with nonzero distances still reports zeros
      row.p = make_planes(ONE, ONE, ONE, VMAX, ONE, ONE, ONE, VMIN, 0, 0, ONE, 7);
      directed.push_back(row);
      // tiny diagonal, big distances: every coordinate saturates high
      row.p = make_planes(1, 0, 0, VMAX, 0, 1, 0, VMAX, 0, 0, 1, VMAX);
      row.fixed = '{VMAX, VMAX, VMAX, 1'b1, 1'b1};
      directed.push_back(row);
      // and low
      row.p = make_planes(1, 0, 0, VMIN, 0, 1, 0, VMIN, 0, 0, 1, VMIN);
      row.fixed = '{VMIN, VMIN, VMIN, 1'b1, 1'b1};
      directed.push_back(row);
      // remaining rows use the predictor
      row.has_fixed = 1'b0;
      directed.push_back('{make_planes(VMAX, VMIN, 0, VMAX, VMIN, VMAX, VMAX, VMIN,
                                       0, VMAX, VMIN, VMAX), 1'b0, want});
      directed.push_back('{make_planes(VMIN, 0, 0, VMAX, 0, VMIN, 0, VMIN,
                                       0, 0, VMIN, 1), 1'b0, want});
      directed.push_back('{make_planes(VMAX, 0, 0, VMIN, 0, VMAX, 0, VMAX,
                                       0, 0, VMAX, -1), 1'b0, want});
      directed.push_back('{make_planes(-1, -1, -1, -1, -1, -1, -1, -1,
                                       -1, -1, -1, -1), 1'b0, want});
      directed.push_back('{make_planes(3, 0, 0, 1, 0, 3, 0, -1, 0, 0, -3, 2), 1'b0, want});
      directed.push_back('{make_planes(2 << FB, ONE, 0, 7, ONE, 3 << FB, ONE, -9,
                                       0, ONE, 4 << FB, 11), 1'b0, want});

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         want = directed[i].has_fixed ? directed[i].fixed : solve_planes(directed[i].p);
         send_planes(directed[i].p, want);
         if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 3));
      end

      // random part in bursts; some long gaps land on every pipeline phase
      for (int n = 0; n < NUM_RANDOM; ) begin
         burst = $urandom_range(1, 40);
         for (int b = 0; b < burst && n < NUM_RANDOM; b++, n++) begin
            p = random_planes();
            send_planes(p, solve_planes(p));
         end
         case ($urandom_range(0, 3))
            0:       ;
            1:       idle_cycles($urandom_range(1, 4));
            2:       idle_cycles($urandom_range(5, LATENCY + 5));
            default: idle_cycles($urandom_range(1, 12));
         endcase
      end
      start <= 1'b0;

      wait_count = 0;
      while (expected_points.size() != 0 && wait_count < 20 * LATENCY) begin
         @(posedge clock);
         wait_count++;
      end
      repeat (LATENCY + 4) @(posedge clock);

      if (error_count == 0 && expected_points.size() == 0) begin
         $display("** three_plane_intersection: PASSED **");
      end else begin
         if (expected_points.size() != 0)
            $display("%0d results never arrived", expected_points.size());
         $display("** three_plane_intersection: FAILED **");
      end
      $finish;
   end
endmodule
